FILE: src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared constants and types for the complex arithmetic unit
// Q16.16 word format, operation and status codes.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS + 1;            // sum of two products
  localparam int NUM_BITS  = PROD_BITS + FRAC_BITS;        // shifted dividend
  localparam int QBITS     = NUM_BITS;                     // quotient bits
  localparam int TDATA_IN  = 136;                          // 2+4*32 -> 130 -> bytes
  localparam int TDATA_OUT = 72;                           // 66 -> bytes

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

endpackage

FILE: src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Stages: capture, products, combine, divider load, one per quotient bit, output register.
// Throughput: one transaction per cycle while not stalled by out_tready; all ops share the
// same pipeline, so depth is set by the restoring divider, one stage per quotient bit.
// Reset: synchronous active-low rst_n clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex add/sub/mul/div in signed Q16.16
// Products, |b|^2, pipelined long division, saturation and status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // op[1:0], a_re[33:2], a_im[65:34], b_re[97:66], b_im[129:98], zeros
  input  logic [cau_pkg::TDATA_IN-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // r_re[31:0], r_im[63:32], status[65:64], zeros
  output logic [cau_pkg::TDATA_OUT-1:0]  out_tdata
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int PB = cau_pkg::PROD_BITS;
  localparam int NB = cau_pkg::NUM_BITS;
  localparam int QB = cau_pkg::QBITS;
  localparam int DB = 2 * W + 1;              // |b|^2 width (unsigned)

  logic adv;
  assign adv = out_tready || !out_tvalid;
  assign in_tready = adv;

  // ---------------- stage 1: capture operands
  logic                v1_r;
  logic [1:0]          op1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
    if (adv) begin
      op1_r <= in_tdata[1:0];
      ar1_r <= in_tdata[2 +: W];
      ai1_r <= in_tdata[2 + W +: W];
      br1_r <= in_tdata[2 + 2*W +: W];
      bi1_r <= in_tdata[2 + 3*W +: W];
    end
  end

  // ---------------- stage 2: four cross products, |b|^2 terms and add/sub sums
  logic                 v2_r;
  logic [1:0]           op2_r;
  logic signed [2*W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [W:0]    sa_r, sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      op2_r  <= op1_r;
      p_rr_r <= ar1_r * br1_r;
      p_ii_r <= ai1_r * bi1_r;
      p_ri_r <= ar1_r * bi1_r;
      p_ir_r <= ai1_r * br1_r;
      p_bb_r <= br1_r * br1_r;
      p_cc_r <= bi1_r * bi1_r;
      sa_r   <= (op1_r == cau_pkg::OP_SUB) ? ({ar1_r[W-1], ar1_r} - {br1_r[W-1], br1_r})
                                            : ({ar1_r[W-1], ar1_r} + {br1_r[W-1], br1_r});
      sb_r   <= (op1_r == cau_pkg::OP_SUB) ? ({ai1_r[W-1], ai1_r} - {bi1_r[W-1], bi1_r})
                                            : ({ai1_r[W-1], ai1_r} + {bi1_r[W-1], bi1_r});
    end
  end

  // ---------------- stage 3: combine products, set up division magnitudes
  logic                 v3_r;
  logic [1:0]           op3_r;
  logic signed [PB-1:0] x_re_r, x_im_r;     // add/sub/mul results, shifted right by F for mul
  logic [NB-1:0]        nre3_r, nim3_r;     // dividend magnitudes
  logic                 sre3_r, sim3_r;     // dividend signs
  logic [DB-1:0]        den3_r;
  logic                 dz3_r;

  logic signed [PB-1:0] e_rr, e_ii, e_ri, e_ir, mre, mim, dre, dim;
  logic signed [NB-1:0] nre_s, nim_s;
  logic [DB-1:0]        den_c;

  always_comb begin
    e_rr  = PB'(p_rr_r);
    e_ii  = PB'(p_ii_r);
    e_ri  = PB'(p_ri_r);
    e_ir  = PB'(p_ir_r);
    mre   = e_rr - e_ii;
    mim   = e_ri + e_ir;
    dre   = e_rr + e_ii;
    dim   = e_ir - e_ri;
    nre_s = NB'(dre) <<< F;
    nim_s = NB'(dim) <<< F;
    den_c = DB'($unsigned(p_bb_r)) + DB'($unsigned(p_cc_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      op3_r  <= op2_r;
      x_re_r <= (op2_r == cau_pkg::OP_MUL) ? (mre >>> F) : PB'(sa_r);
      x_im_r <= (op2_r == cau_pkg::OP_MUL) ? (mim >>> F) : PB'(sb_r);
      sre3_r <= nre_s[NB-1];
      sim3_r <= nim_s[NB-1];
      nre3_r <= nre_s[NB-1] ? NB'(-nre_s) : NB'(nre_s);
      nim3_r <= nim_s[NB-1] ? NB'(-nim_s) : NB'(nim_s);
      den3_r <= den_c;
      dz3_r  <= (den_c == '0);
    end
  end

  // ---------------- divider stages: one restoring step per stage, both parts
  logic                 dv_r   [QB+1];
  logic [1:0]           dop_r  [QB+1];
  logic signed [PB-1:0] dxr_r  [QB+1];
  logic signed [PB-1:0] dxi_r  [QB+1];
  logic [NB-1:0]        dnr_r  [QB+1];   // remaining dividend bits, shifting left
  logic [NB-1:0]        dni_r  [QB+1];
  logic [DB:0]          drr_r  [QB+1];   // partial remainders
  logic [DB:0]          dri_r  [QB+1];
  logic [QB-1:0]        dqr_r  [QB+1];
  logic [QB-1:0]        dqi_r  [QB+1];
  logic [DB-1:0]        dd_r   [QB+1];
  logic                 dsr_r  [QB+1];
  logic                 dsi_r  [QB+1];
  logic                 dz_r   [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v3_r;
    end
    if (adv) begin
      dop_r[0] <= op3_r;
      dxr_r[0] <= x_re_r;
      dxi_r[0] <= x_im_r;
      dnr_r[0] <= nre3_r;
      dni_r[0] <= nim3_r;
      drr_r[0] <= '0;
      dri_r[0] <= '0;
      dqr_r[0] <= '0;
      dqi_r[0] <= '0;
      dd_r[0]  <= den3_r;
      dsr_r[0] <= sre3_r;
      dsi_r[0] <= sim3_r;
      dz_r[0]  <= dz3_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DB:0] tr, ti;
    logic        gr, gi;
    always_comb begin
      tr = {drr_r[k][DB-1:0], dnr_r[k][NB-1]};
      ti = {dri_r[k][DB-1:0], dni_r[k][NB-1]};
      gr = (tr >= {1'b0, dd_r[k]});
      gi = (ti >= {1'b0, dd_r[k]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
      if (adv) begin
        dop_r[k+1] <= dop_r[k];
        dxr_r[k+1] <= dxr_r[k];
        dxi_r[k+1] <= dxi_r[k];
        dnr_r[k+1] <= dnr_r[k] << 1;
        dni_r[k+1] <= dni_r[k] << 1;
        drr_r[k+1] <= gr ? (tr - {1'b0, dd_r[k]}) : tr;
        dri_r[k+1] <= gi ? (ti - {1'b0, dd_r[k]}) : ti;
        dqr_r[k+1] <= {dqr_r[k][QB-2:0], gr};
        dqi_r[k+1] <= {dqi_r[k][QB-2:0], gi};
        dd_r[k+1]  <= dd_r[k];
        dsr_r[k+1] <= dsr_r[k];
        dsi_r[k+1] <= dsi_r[k];
        dz_r[k+1]  <= dz_r[k];
      end
    end
  end

  // ---------------- final stage: sign, saturation, status
  localparam logic signed [QB:0] MAXV = (QB+1)'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [QB:0] MINV = -(QB+1)'(64'sd1 <<< (W-1));

  logic signed [QB:0] vre, vim;
  logic               cre_hi, cre_lo, cim_hi, cim_lo;
  logic [W-1:0]       rre, rim;
  logic [1:0]         stat;

  always_comb begin
    if (dop_r[QB] == cau_pkg::OP_DIV) begin
      vre = dsr_r[QB] ? -$signed({1'b0, dqr_r[QB]}) : $signed({1'b0, dqr_r[QB]});
      vim = dsi_r[QB] ? -$signed({1'b0, dqi_r[QB]}) : $signed({1'b0, dqi_r[QB]});
    end else begin
      vre = (QB+1)'(dxr_r[QB]);
      vim = (QB+1)'(dxi_r[QB]);
    end
    cre_hi = vre > MAXV;
    cre_lo = vre < MINV;
    cim_hi = vim > MAXV;
    cim_lo = vim < MINV;
    rre = cre_hi ? MAXV[W-1:0] : (cre_lo ? MINV[W-1:0] : vre[W-1:0]);
    rim = cim_hi ? MAXV[W-1:0] : (cim_lo ? MINV[W-1:0] : vim[W-1:0]);
    stat = (cre_hi || cre_lo || cim_hi || cim_lo) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    if (dop_r[QB] == cau_pkg::OP_DIV && dz_r[QB]) begin
      rre  = '0;
      rim  = '0;
      stat = cau_pkg::ST_DIV0;
    end
  end

  logic                           out_tvalid_r;
  logic [cau_pkg::TDATA_OUT-1:0]  out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= dv_r[QB];
    end
    if (adv) begin
      out_tdata_r <= {6'd0, stat, rim, rre};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // stalled output must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  // divide-by-zero only reported with zeroed parts
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] == cau_pkg::ST_DIV0 |-> out_tdata[63:0] == '0)
    else $error("div0 with nonzero result");
  // status code 3 never appears
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != 2'd3)
    else $error("illegal status");
  // first stage advances with the pipeline
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted transaction dropped");
`endif

endmodule

FILE: bench/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit: self-checking bench for the complex ALU
// Directed table then random operands; results checked against a 128-bit
// integer model of the Q16.16 add/sub/mul/div with saturation.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;

  localparam int N_RANDOM    = 1630;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN       = 120;   // extra idle clocks after the last result

  typedef struct packed {
    cau_pkg::op_t op;
    logic [31:0]  a_re, a_im, b_re, b_im;
  } operands_t;

  typedef struct packed {
    logic [31:0]      r_re, r_im;
    cau_pkg::status_t status;
  } cplx_result_t;

  typedef struct packed {
    operands_t    opnd;
    logic         typed;
    cplx_result_t res;
  } vector_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [cau_pkg::TDATA_IN-1:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [cau_pkg::TDATA_OUT-1:0] out_tdata;

  complex_arithmetic_unit dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  cplx_result_t pending_results[$];
  int n_sent = 0, n_checked = 0, n_errors = 0, n_sat = 0, n_div0 = 0;
  int tx_idle = 26, rx_idle = 62, cycles = 0;
  logic rx_hold = 0;
  int op_count[4] = '{0, 0, 0, 0};

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic hit);
    if (v > 128'sd2147483647) begin
      hit = 1;
      return 32'h7fffffff;
    end else if (v < -128'sd2147483648) begin
      hit = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic cplx_result_t complex_op(input operands_t x);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic hit;
    cplx_result_t r;
    ar = $signed(x.a_re); ai = $signed(x.a_im);
    br = $signed(x.b_re); bi = $signed(x.b_im);
    hit = 0;
    case (x.op)
      cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::OP_MUL: begin
        re = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
        im = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.r_re = '0; r.r_im = '0; r.status = cau_pkg::ST_DIV0;
          return r;
        end
        // signed division truncates toward zero
        re = ((ar * br + ai * bi) <<< cau_pkg::FRAC_BITS) / den;
        im = ((ai * br - ar * bi) <<< cau_pkg::FRAC_BITS) / den;
      end
    endcase
    r.r_re = clamp32(re, hit);
    r.r_im = clamp32(im, hit);
    r.status = hit ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    return r;
  endfunction

  vector_t directed[] = '{
    '{'{cau_pkg::OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0}, 1, '{32'h0, 32'h0, cau_pkg::ST_OK}},
    '{'{cau_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000}, 1,
      '{32'h7fffffff, 32'h80000000, cau_pkg::ST_SAT}},
    '{'{cau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff}, 1,
      '{32'h80000000, 32'h7fffffff, cau_pkg::ST_SAT}},
    '{'{cau_pkg::OP_SUB, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h0}, 1,
      '{32'h0, 32'h0, cau_pkg::ST_OK}},
    '{'{cau_pkg::OP_MUL, 32'h10000, 32'h0, 32'h10000, 32'h0}, 1,
      '{32'h10000, 32'h0, cau_pkg::ST_OK}},
    '{'{cau_pkg::OP_MUL, 32'h0, 32'h10000, 32'h0, 32'h10000}, 1,
      '{32'hffff0000, 32'h0, cau_pkg::ST_OK}},
    '{'{cau_pkg::OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 0, '0},
    '{'{cau_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff}, 0, '0},
    '{'{cau_pkg::OP_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0}, 0, '0},
    '{'{cau_pkg::OP_DIV, 32'h12345, 32'h678, 32'h0, 32'h0}, 1,
      '{32'h0, 32'h0, cau_pkg::ST_DIV0}},
    '{'{cau_pkg::OP_DIV, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0}, 1,
      '{32'h0, 32'h0, cau_pkg::ST_DIV0}},
    '{'{cau_pkg::OP_DIV, 32'h10000, 32'h0, 32'h10000, 32'h0}, 1,
      '{32'h10000, 32'h0, cau_pkg::ST_OK}},
    '{'{cau_pkg::OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h0}, 1,
      '{32'h7fffffff, 32'h7fffffff, cau_pkg::ST_SAT}},
    '{'{cau_pkg::OP_DIV, 32'h80000000, 32'h80000000, 32'h1, 32'h1}, 0, '0},
    '{'{cau_pkg::OP_DIV, 32'hffffffff, 32'h1, 32'h7fffffff, 32'h80000000}, 0, '0},
    '{'{cau_pkg::OP_DIV, 32'h80000000, 32'h0, 32'h80000000, 32'h0}, 0, '0},
    '{'{cau_pkg::OP_DIV, 32'h1, 32'hffffffff, 32'h0, 32'hffffffff}, 0, '0}
  };

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(3) - 2;                      // near zero
      2: return {{12{$urandom_range(1) == 1}}, 20'($urandom)}; // moderate
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input operands_t x, input logic typed, input cplx_result_t res);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {6'b0, x.b_im, x.b_re, x.a_im, x.a_re, x.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(typed ? res : complex_op(x));
    op_count[x.op]++;
    n_sent++;
    if (n_sent == 550) begin
      tx_idle = 62; rx_idle = 26;
    end else if (n_sent == 1100) begin
      tx_idle = 0; rx_idle = 0;
    end
  endtask

  always @(posedge clk) out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);

  // long receiver stall while the sender keeps pushing
  initial begin
    wait (n_sent >= 700);
    rx_hold = 1;
    repeat (400) @(posedge clk);
    rx_hold = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    cplx_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.r_re   = out_tdata[31:0];
      got.r_im   = out_tdata[63:32];
      got.status = cau_pkg::status_t'(out_tdata[65:64]);
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.status == cau_pkg::ST_SAT) n_sat++;
        if (got.status == cau_pkg::ST_DIV0) n_div0++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: re %h/%h im %h/%h status %0d/%0d (exp/got)", n_checked,
                     want.r_re, got.r_re, want.r_im, got.r_im, want.status, got.status);
        end
      end
    end
  end

  initial begin
    operands_t x;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    foreach (directed[i]) send_item(directed[i].opnd, directed[i].typed, directed[i].res);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 1300) begin
        in_tvalid <= 0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      x.op = cau_pkg::op_t'($urandom_range(3));
      x.a_re = rand_word(); x.a_im = rand_word();
      x.b_re = rand_word(); x.b_im = rand_word();
      if (x.op == cau_pkg::OP_DIV && $urandom_range(15) == 0) begin
        x.b_re = '0; x.b_im = '0;
      end
      send_item(x, 0, '0);
    end
    in_tvalid <= 0;
    wait (pending_results.size() == 0);
    repeat (DRAIN) @(posedge clk);
    n_errors += pending_results.size();
    $display("%0d transactions (add %0d sub %0d mul %0d div %0d), %0d results checked",
             n_sent, op_count[0], op_count[1], op_count[2], op_count[3], n_checked);
    $display("saturated %0d, divide by zero %0d, errors %0d", n_sat, n_div0, n_errors);
    if (n_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
